// ===== src/rlecs_pkg.sv =====
`default_nettype none

package rlecs_pkg;

    // fixed field widths
    localparam int unsigned RUN_W      = 32;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned POS_W      = 2;

    // group coding
    localparam int unsigned GROUP_W    = 5;
    localparam int unsigned GRP_CNT_W  = 3;
    localparam logic [GRP_CNT_W-1:0] GROUP_LAST = 3'd6;
    localparam logic [CHAR_W-1:0]    CHAR_OFFSET = 7'd48;

    // position within a mask, saturating
    localparam logic [POS_W-1:0] POS_FIRST = 2'd0;
    localparam logic [POS_W-1:0] POS_DELTA = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic take;
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic last_group;
    } status_t;

endpackage

`default_nettype wire

// ===== src/rlecs_in_if.sv =====
`default_nettype none

interface rlecs_in_if;
    logic                           valid;
    logic                           ready;
    logic [rlecs_pkg::RUN_W-1:0]    run_count;
    logic                           first_of_mask;

    modport source (output valid, output run_count, output first_of_mask, input ready);
    modport sink   (input valid, input run_count, input first_of_mask, output ready);
endinterface

`default_nettype wire

// ===== src/rlecs_out_if.sv =====
`default_nettype none

interface rlecs_out_if;
    logic                           valid;
    logic                           ready;
    logic [rlecs_pkg::CHAR_W-1:0]   code_char;
    logic                           last_of_count;

    modport source (output valid, output code_char, output last_of_count, input ready);
    modport sink   (input valid, input code_char, input last_of_count, output ready);
endinterface

`default_nettype wire

// ===== src/rlecs_ctrl.sv =====
`default_nettype none

module rlecs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire rlecs_pkg::status_t status,
    output rlecs_pkg::cmd_t        cmd
);

    rlecs_pkg::state_t state_reg;
    rlecs_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlecs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlecs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rlecs_pkg::ST_RUN;
                end
            end
            rlecs_pkg::ST_RUN:
            begin
                if (status.slot_free && status.last_group)
                begin
                    state_next = rlecs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rlecs_pkg::ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            rlecs_pkg::ST_IDLE:
            begin
                cmd.take = 1'b1;
                cmd.load = in_valid;
            end
            rlecs_pkg::ST_RUN:
            begin
                cmd.step = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/rlecs_datapath.sv =====
`default_nettype none

module rlecs_datapath #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire rlecs_pkg::cmd_t                cmd,
    input  wire logic [rlecs_pkg::RUN_W-1:0]    run_count,
    input  wire logic                           first_of_mask,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [rlecs_pkg::CHAR_W-1:0]        code_char,
    output logic                                last_of_count,
    output rlecs_pkg::status_t                  status
);

    localparam int unsigned CUR_W =
        (COUNT_BITS < rlecs_pkg::RUN_W) ? COUNT_BITS : rlecs_pkg::RUN_W;
    localparam int unsigned DW = CUR_W + 1;

    logic [CUR_W-1:0]                   prev_one_reg;
    logic [CUR_W-1:0]                   prev_two_reg;
    logic [rlecs_pkg::POS_W-1:0]        pos_reg;
    logic [DW-1:0]                      val_reg;
    logic [rlecs_pkg::GRP_CNT_W-1:0]    grp_reg;
    logic                               out_valid_reg;
    logic [rlecs_pkg::CHAR_W-1:0]       char_reg;
    logic                               last_reg;

    logic [CUR_W-1:0]                   cur;
    logic [rlecs_pkg::POS_W-1:0]        pos;
    logic [DW-1:0]                      val_next;
    logic [rlecs_pkg::POS_W-1:0]        pos_next;
    logic [rlecs_pkg::GROUP_W-1:0]      group;
    logic [DW-1:0]                      rest;
    logic                               more;
    logic [rlecs_pkg::CHAR_W-1:0]       char_next;

    // count and delta selection on load
    always_comb
    begin
        cur = run_count[CUR_W-1:0];
        pos = first_of_mask ? rlecs_pkg::POS_FIRST : pos_reg;
        if (pos == rlecs_pkg::POS_DELTA)
        begin
            val_next = {1'b0, cur} - {1'b0, prev_two_reg};
        end
        else
        begin
            val_next = {1'b0, cur};
        end
        if (pos == rlecs_pkg::POS_DELTA)
        begin
            pos_next = rlecs_pkg::POS_DELTA;
        end
        else
        begin
            pos_next = pos + 1'b1;
        end
    end

    // current group and continuation
    always_comb
    begin
        group = val_reg[rlecs_pkg::GROUP_W-1:0];
        rest  = DW'($signed(val_reg) >>> rlecs_pkg::GROUP_W);
        if (group[rlecs_pkg::GROUP_W-1])
        begin
            more = ~(&rest);
        end
        else
        begin
            more = |rest;
        end
        if (grp_reg == rlecs_pkg::GROUP_LAST)
        begin
            more = 1'b0;
        end
        char_next = {1'b0, more, group} + rlecs_pkg::CHAR_OFFSET;
    end

    // history and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_one_reg <= '0;
            prev_two_reg <= '0;
            pos_reg      <= rlecs_pkg::POS_FIRST;
        end
        else if (cmd.load)
        begin
            prev_two_reg <= prev_one_reg;
            prev_one_reg <= cur;
            pos_reg      <= pos_next;
        end
    end

    // group shifter
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= val_next;
            grp_reg <= '0;
        end
        else if (cmd.step)
        begin
            val_reg <= rest;
            grp_reg <= grp_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            char_reg <= char_next;
            last_reg <= ~more;
        end
    end

    assign out_valid         = out_valid_reg;
    assign code_char         = char_reg;
    assign last_of_count     = last_reg;
    assign status.slot_free  = ~out_valid_reg | out_ready;
    assign status.last_group = ~more;

endmodule

`default_nettype wire

// ===== src/rle_count_string_encoder_top.sv =====
`default_nettype none

// Compressed RLE count-string encoder. Each transfer on counts carries one run-length
// count and a flag for the first count of a new mask; from the fourth count of a mask
// on, the count two places back is subtracted. The value leaves on chars as printable
// characters, one per cycle while chars is ready, 5 bits each, least significant first,
// with the last character of each count flagged. Each count yields 1 to 7 characters,
// carried by a single output register; a new count is not accepted while the previous
// one is still being emitted. The next count is taken as soon as the last character of
// the previous one sits in the output register. COUNT_BITS (8 to 63) limits how many
// low bits of run_count are used, at most RUN_W (32).
module rle_count_string_encoder_top #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    rlecs_in_if.sink        counts,
    rlecs_out_if.source     chars
);

    rlecs_pkg::cmd_t    cmd;
    rlecs_pkg::status_t status;

    // sequencing
    rlecs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (counts.valid),
        .status   (status),
        .cmd      (cmd)
    );

    // history, delta and group emission
    rlecs_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .run_count     (counts.run_count),
        .first_of_mask (counts.first_of_mask),
        .out_ready     (chars.ready),
        .out_valid     (chars.valid),
        .code_char     (chars.code_char),
        .last_of_count (chars.last_of_count),
        .status        (status)
    );

    assign counts.ready = cmd.take;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_PER_PHASE = 75;
    localparam int unsigned PHASES = 4;

    typedef struct packed {
        logic [rlecs_pkg::RUN_W-1:0] run_count;
        logic                        first_of_mask;
    } count_item_t;

    typedef struct packed {
        logic [rlecs_pkg::CHAR_W-1:0] code_char;
        logic                         last_of_count;
    } code_char_t;

    logic clk = 1'b0;
    logic rst_n;

    rlecs_in_if  counts_if ();
    rlecs_out_if chars_if ();

    rle_count_string_encoder_top #(
        .COUNT_BITS (rlecs_pkg::RUN_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .counts (counts_if),
        .chars  (chars_if)
    );

    // counts waiting to be offered and characters still owed by the block
    count_item_t pending_counts[$];
    code_char_t  expected_chars[$];

    // shadow of the encoder state
    logic [rlecs_pkg::RUN_W-1:0] last_count = '0;
    logic [rlecs_pkg::RUN_W-1:0] count_two_back = '0;
    logic [rlecs_pkg::POS_W-1:0] mask_pos = rlecs_pkg::POS_FIRST;

    int unsigned counts_queued = 0;
    int unsigned counts_taken = 0;
    int unsigned chars_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_left = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          pressure_on = 1'b0;
    bit          hold_done = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // work out the characters for one accepted count and advance the shadow state
    function automatic void encode_count(input logic [rlecs_pkg::RUN_W-1:0] cnt,
                                         input logic first);
        logic [rlecs_pkg::POS_W-1:0]     pos;
        logic signed [63:0]              val;
        logic [rlecs_pkg::GROUP_W-1:0]   grp;
        logic                            more;
        int                              n;
        code_char_t                      ch;
        pos = first ? rlecs_pkg::POS_FIRST : mask_pos;
        val = {32'b0, cnt};
        // from the fourth count on, the count two back is taken off
        if (pos == rlecs_pkg::POS_DELTA)
            val = {32'b0, cnt} - {32'b0, count_two_back};
        n = 0;
        more = 1'b1;
        while (more && n <= int'(rlecs_pkg::GROUP_LAST))
        begin
            grp = val[rlecs_pkg::GROUP_W-1:0];
            val = val >>> rlecs_pkg::GROUP_W;
            // stop once what remains is only sign
            if (grp[rlecs_pkg::GROUP_W-1])
                more = (val != 64'hFFFF_FFFF_FFFF_FFFF);
            else
                more = (val != 64'd0);
            if (n == int'(rlecs_pkg::GROUP_LAST))
                more = 1'b0;
            ch.code_char = {1'b0, more, grp} + rlecs_pkg::CHAR_OFFSET;
            ch.last_of_count = !more;
            expected_chars = {expected_chars, ch};
            n++;
        end
        count_two_back = last_count;
        last_count = cnt;
        mask_pos = (pos < rlecs_pkg::POS_DELTA) ? pos + 1'b1 : rlecs_pkg::POS_DELTA;
    endfunction

    task automatic queue_count(input logic [rlecs_pkg::RUN_W-1:0] cnt, input logic first);
        count_item_t item;
        item.run_count = cnt;
        item.first_of_mask = first;
        pending_counts = {pending_counts, item};
        counts_queued++;
    endtask

    // mostly whole masks with counts of mixed size, some near the count two back
    task automatic queue_random(input int unsigned total);
        int unsigned                 added;
        int unsigned                 len;
        logic [rlecs_pkg::RUN_W-1:0] hist_one;
        logic [rlecs_pkg::RUN_W-1:0] hist_two;
        logic [rlecs_pkg::RUN_W-1:0] cnt;
        added = 0;
        hist_one = '0;
        hist_two = '0;
        while (added < total)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // stray count with a random flag
                queue_count($urandom, 1'($urandom_range(0, 1)));
                added++;
            end
            else
            begin
                len = $urandom_range(1, 9);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: cnt = $urandom_range(0, 40);
                        1: cnt = $urandom_range(0, 65535);
                        2: cnt = $urandom;
                        default: cnt = hist_two + $urandom_range(0, 64) - 32;
                    endcase
                    queue_count(cnt, i == 0);
                    hist_two = hist_one;
                    hist_one = cnt;
                    added++;
                end
            end
        end
    endtask

    // count driver: the model is updated on each transfer
    always @(posedge clk or negedge rst_n)
    begin : drive_counts
        count_item_t next_item;
        if (!rst_n)
        begin
            counts_if.valid <= 1'b0;
            counts_if.run_count <= '0;
            counts_if.first_of_mask <= 1'b0;
        end
        else
        begin
            if (counts_if.valid && counts_if.ready)
            begin
                encode_count(counts_if.run_count, counts_if.first_of_mask);
                counts_taken <= counts_taken + 1;
            end
            if (!counts_if.valid || counts_if.ready)
            begin
                if (pending_counts.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = pending_counts.pop_front();
                    counts_if.valid <= 1'b1;
                    counts_if.run_count <= next_item.run_count;
                    counts_if.first_of_mask <= next_item.first_of_mask;
                end
                else
                begin
                    counts_if.valid <= 1'b0;
                end
            end
        end
    end

    // character monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : watch_chars
        code_char_t seen;
        code_char_t want;
        if (!rst_n)
        begin
            chars_if.ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                seen.code_char = chars_if.code_char;
                seen.last_of_count = chars_if.last_of_count;
                chars_seen <= chars_seen + 1;
                if (expected_chars.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected character: code_char=%0d last_of_count=%0b",
                                 seen.code_char, seen.last_of_count);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (seen.code_char !== want.code_char
                        || seen.last_of_count !== want.last_of_count)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch: char exp %0d got %0d, last exp %0b got %0b",
                                     want.code_char, seen.code_char,
                                     want.last_of_count, seen.last_of_count);
                    end
                end
            end
            // one long hold-off so that the block backs up onto its input
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                chars_if.ready <= 1'b0;
            end
            else if (pressure_on && !hold_done && chars_seen >= 10)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                chars_if.ready <= 1'b0;
            end
            else
            begin
                chars_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any useful transfer while work is outstanding
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (counts_if.valid && counts_if.ready)
                idle_cycles <= 0;
            else if (chars_if.valid && chars_if.ready && expected_chars.size() != 0)
                idle_cycles <= 0;
            else if (counts_taken != counts_queued || expected_chars.size() != 0)
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed counts: no mask start after reset, early counts, signed deltas,
        // widest values and the group bound
        queue_count(32'd5, 1'b0);
        queue_count(32'd31, 1'b0);
        queue_count(32'd16, 1'b0);
        queue_count(32'd100, 1'b0);
        queue_count(32'd0, 1'b0);
        queue_count(32'd0, 1'b1);
        queue_count(32'hFFFF_FFFF, 1'b0);
        queue_count(32'd15, 1'b0);
        queue_count(32'd0, 1'b0);
        queue_count(32'hFFFF_FFFF, 1'b0);
        queue_count(32'hFFFF_FFFF, 1'b0);
        queue_count(32'hFFFF_FFFF, 1'b1);
        queue_count(32'h8000_0000, 1'b0);
        queue_count(32'h7FFF_FFFF, 1'b0);
        queue_count(32'h8000_0001, 1'b0);
        queue_count(32'h7FFF_FFFF, 1'b0);
        queue_count(32'h5555_5555, 1'b0);
        queue_count(32'hAAAA_AAAA, 1'b1);
        queue_count(32'd1, 1'b0);
        queue_count(32'd47, 1'b0);
        queue_count(32'hAAAA_AAAA, 1'b0);
        queue_count(32'd17, 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            @(negedge clk);
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    pressure_on = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 67;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                end
            endcase
            queue_random(RANDOM_PER_PHASE);
            wait (counts_taken == counts_queued && expected_chars.size() == 0);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire
